// ===== design/ttol_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttol_pkg: shared types and constants of the latency matcher
// Record and result layouts, window depth, cell and divider control bundles.
// ----------------------------------------------------------------------------
package ttol_pkg;

	localparam int WINDOW_DEPTH = 5;
	localparam int SRCH_W       = $clog2(WINDOW_DEPTH + 1);

	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [1:0] KIND_OTHER     = 2'd0;
	localparam logic [1:0] KIND_NEW_ORDER = 2'd1;
	localparam logic [1:0] KIND_ORDER_MSG = 2'd2;

	typedef struct packed {
		logic [30:0]        rec_time;
		logic [1:0]         rec_kind;
		logic [31:0]        instrument_id;
		logic signed [31:0] rec_price;
		logic [7:0]         side_code;
	} rec_t;

	typedef struct packed {
		logic               matched;
		logic signed [31:0] latency;
		logic [31:0]        match_total;
		logic signed [31:0] lat_min;
		logic signed [31:0] lat_max;
		logic signed [31:0] lat_avg;
	} res_t;

	// search result travelling down the cell row
	typedef struct packed {
		logic        found;
		logic [30:0] tstamp;
	} carry_t;

	typedef struct packed {
		logic shift;
		logic advance;
	} cell_ctl_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== design/ttol_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttol_if: valid/ready channels of the latency matcher
// One channel for incoming records, one for outgoing results.
// ----------------------------------------------------------------------------
interface ttol_rec_if import ttol_pkg::*; ();
	logic valid;
	logic ready;
	rec_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ttol_res_if import ttol_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ttol_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttol_cell: one window slot
// Holds one past record, checks it against the probe and passes the search
// result and, on shift, its record to the next older slot.
// ----------------------------------------------------------------------------
module ttol_cell import ttol_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  rec_t      probe,
	input  rec_t      ent_in,
	input  logic      vld_in,
	output rec_t      ent_out,
	output logic      vld_out,
	input  carry_t    carry_in,
	output carry_t    carry_out
);

	rec_t   entry_q;
	logic   vld_q;
	carry_t carry_q;
	logic   hit;

	assign hit = vld_q && (entry_q.rec_kind == KIND_ORDER_MSG) &&
		(entry_q.instrument_id == probe.instrument_id) &&
		($signed(entry_q.rec_price) <= $signed(probe.rec_price)) &&
		(entry_q.side_code != probe.side_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= ent_in;
		end
		// newer slots win: keep what came from upstream if it already found one
		if (ctl.advance) begin
			carry_q.found  <= carry_in.found | hit;
			carry_q.tstamp <= carry_in.found ? carry_in.tstamp : entry_q.rec_time;
		end
	end

	assign ent_out   = entry_q;
	assign vld_out   = vld_q;
	assign carry_out = carry_q;

endmodule

// ===== design/ttol_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttol_div: serial unsigned divider, 64 by 32 bits, 32-bit quotient
// Restoring division, one quotient bit a cycle. The dividend's upper half
// must be below the divisor.
// ----------------------------------------------------------------------------
module ttol_div import ttol_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_ctl_t    ctl,
	output div_sts_t    sts,
	output logic [31:0] quotient
);

	logic [31:0]          rem_q;
	logic [31:0]          quo_q;
	logic [31:0]          dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [32:0]          trial;
	logic [32:0]          diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= ctl.dividend[63:32];
			quo_q <= ctl.dividend[31:0];
			dsr_q <= ctl.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.start && busy_q))
		else $error("divider restarted while busy");

endmodule

// ===== design/tick_to_order_latency_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_to_order_latency_matcher: new-order to order-message latency matcher
// Searches a window of recent records for the newest matching order message
// and keeps running latency statistics with a truncating average.
// ----------------------------------------------------------------------------
//
//   channel   role    handshake      transaction
//   -------   -----   ------------   ---------------------------------------
//   rec_in    sink    valid/ready    one parsed record (time, kind, token,
//                                    price, side)
//   res_out   source  valid/ready    one result per record (match, latency,
//                                    count, min, max, average)
//
// One record at a time: a new record is taken only in the idle state, once
// the result of the last one has gone into the output register. The search
// walks the cell row one slot a cycle; a new match below count saturation
// then recomputes the average through the prep state and the serial divider.
// arst_n clears the window valid bits and all statistics; no clearing pass.
// A stalled result sits in the output register while the next record is
// accepted and processed; it then waits in the finish state until taken.
// ----------------------------------------------------------------------------
module tick_to_order_latency_matcher import ttol_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ttol_rec_if.sink          rec_in,
	ttol_res_if.source        res_out
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SEARCH = 6'b000010,
		ST_UPDATE = 6'b000100,
		ST_PREP   = 6'b001000,
		ST_DIVIDE = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q;

	// record under search
	rec_t probe_q;

	// search step counter
	logic [SRCH_W-1:0] srch_q;

	// running statistics
	logic signed [31:0] run_min_q;
	logic signed [31:0] run_max_q;
	logic [63:0]        run_sum_q;
	logic [31:0]        run_count_q;
	logic signed [31:0] run_avg_q;

	// per-record results
	logic               matched_q;
	logic signed [31:0] latency_q;
	logic               neg_q;

	// output register
	res_t out_q;
	logic out_valid_q;

	// cell row
	rec_t      ent   [WINDOW_DEPTH];
	logic      vld   [WINDOW_DEPTH];
	carry_t    carry [WINDOW_DEPTH];
	cell_ctl_t cell_ctl;

	div_ctl_t    div_ctl;
	div_sts_t    div_sts;
	logic [31:0] quotient;

	logic               in_xact;
	logic               out_free;
	logic               hit;
	logic [31:0]        lat;
	logic [63:0]        sum_mag;
	logic [31:0]        avg_next;

	assign in_xact  = rec_in.valid && rec_in.ready;
	assign out_free = !out_valid_q || res_out.ready;

	assign rec_in.ready  = (state_q == ST_IDLE);
	assign res_out.valid = out_valid_q;
	assign res_out.data  = out_q;

	// Advance the search one slot a cycle; shift the window once the answer
	// has reached the oldest slot.
	assign cell_ctl.advance = (state_q == ST_SEARCH);
	assign cell_ctl.shift   = (state_q == ST_UPDATE);

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				ttol_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.ctl       (cell_ctl),
					.probe     (probe_q),
					.ent_in    (probe_q),
					.vld_in    (1'b1),
					.ent_out   (ent[gi]),
					.vld_out   (vld[gi]),
					.carry_in  ('0),
					.carry_out (carry[gi])
				);
			end else begin : g_body
				ttol_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.ctl       (cell_ctl),
					.probe     (probe_q),
					.ent_in    (ent[gi-1]),
					.vld_in    (vld[gi-1]),
					.ent_out   (ent[gi]),
					.vld_out   (vld[gi]),
					.carry_in  (carry[gi-1]),
					.carry_out (carry[gi])
				);
			end
		end
	endgenerate

	// Only new orders may match; the oldest slot now holds the newest hit.
	assign hit = carry[WINDOW_DEPTH-1].found && (probe_q.rec_kind == KIND_NEW_ORDER);
	assign lat = {1'b0, probe_q.rec_time} - {1'b0, carry[WINDOW_DEPTH-1].tstamp};

	assign sum_mag  = run_sum_q[63] ? (64'd0 - run_sum_q) : run_sum_q;
	assign avg_next = neg_q ? (32'd0 - quotient) : quotient;

	assign div_ctl.start    = (state_q == ST_PREP);
	assign div_ctl.dividend = sum_mag;
	assign div_ctl.divisor  = run_count_q;

	ttol_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.sts      (div_sts),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			srch_q      <= '0;
			out_valid_q <= 1'b0;
			run_min_q   <= '0;
			run_max_q   <= '0;
			run_sum_q   <= '0;
			run_count_q <= '0;
			run_avg_q   <= '0;
		end else begin
			// load a finished result, or drop the pending one once taken
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res_out.valid && res_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xact) begin
						srch_q  <= '0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					srch_q <= srch_q + 1'b1;
					if (srch_q == SRCH_W'(WINDOW_DEPTH - 1)) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (hit) begin
						if (run_count_q == '0) begin
							run_min_q <= lat;
							run_max_q <= lat;
						end else begin
							if ($signed(lat) < run_min_q) run_min_q <= lat;
							if ($signed(lat) > run_max_q) run_max_q <= lat;
						end
						// freeze count and sum at saturation; average stays as is
						if (run_count_q != '1) begin
							run_sum_q   <= run_sum_q + {{32{lat[31]}}, lat};
							run_count_q <= run_count_q + 1'b1;
							state_q     <= ST_PREP;
						end else begin
							state_q <= ST_FINISH;
						end
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_PREP: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_sts.done) begin
						run_avg_q <= avg_next;
						state_q   <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xact) begin
			probe_q <= rec_in.data;
		end
		if (state_q == ST_UPDATE) begin
			matched_q <= hit;
			latency_q <= hit ? lat : '0;
		end
		if (state_q == ST_PREP) begin
			neg_q <= run_sum_q[63];
		end
		if (state_q == ST_FINISH && out_free) begin
			out_q.matched     <= matched_q;
			out_q.latency     <= latency_q;
			out_q.match_total <= run_count_q;
			out_q.lat_min     <= run_min_q;
			out_q.lat_max     <= run_max_q;
			out_q.lat_avg     <= run_avg_q;
		end
	end

	a_accept_starts_search: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> (state_q == ST_SEARCH))
		else $error("accepted record did not start a search");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (run_count_q >= $past(run_count_q)))
		else $error("match count went backwards");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(run_count_q != '0) |-> (run_min_q <= run_max_q))
		else $error("running minimum above running maximum");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> (run_count_q != '0))
		else $error("divider started with a zero divisor");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_out.ready) |=> (out_valid_q && $stable(out_q)))
		else $error("pending result overwritten");

endmodule
